### sv/tabular_q_learning_update_unit_macros.svh
`ifndef TABULAR_Q_LEARNING_UPDATE_UNIT_MACROS_SVH
`define TABULAR_Q_LEARNING_UPDATE_UNIT_MACROS_SVH

// check sampled at the rising clock edge, skipped while reset is low
`define TQLU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds while reset is low
`define TQLU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/tqlu_pkg.sv
package tqlu_pkg;

  // fixed field widths of the streams
  localparam int unsigned ST_FIELD_W   = 8;
  localparam int unsigned ACT_FIELD_W  = 2;
  localparam int unsigned Q_FIELD_W    = 32;
  localparam int unsigned CHG_W        = 31;
  localparam int unsigned CNT_FIELD_W  = 16;
  localparam int unsigned IN_TDATA_W   = 56;
  localparam int unsigned OUT_TDATA_W  = 112;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - (Q_FIELD_W + 2 * CHG_W + CNT_FIELD_W);
  localparam int unsigned COEF_W       = 16;

  localparam logic [CHG_W-1:0] CHG_MAX = {CHG_W{1'b1}};

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_Q         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EPISODE_STEPS = 2'd3;

  localparam logic [COEF_W-1:0]      LR_RESET       = 16'd6554;
  localparam logic [COEF_W-1:0]      DISCOUNT_RESET = 16'd64881;
  localparam logic [CNT_FIELD_W-1:0] MAX_STEPS_RESET = 16'd0;

  // microcode step addresses
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] STEP_CLR    = 4'd0;
  localparam logic [PC_W-1:0] STEP_IDLE   = 4'd1;
  localparam logic [PC_W-1:0] STEP_RD_VS  = 4'd2;
  localparam logic [PC_W-1:0] STEP_CHK_S  = 4'd3;
  localparam logic [PC_W-1:0] STEP_INIT_S = 4'd4;
  localparam logic [PC_W-1:0] STEP_RD_VN  = 4'd5;
  localparam logic [PC_W-1:0] STEP_CHK_N  = 4'd6;
  localparam logic [PC_W-1:0] STEP_INIT_N = 4'd7;
  localparam logic [PC_W-1:0] STEP_SCAN   = 4'd8;
  localparam logic [PC_W-1:0] STEP_RD_Q   = 4'd9;
  localparam logic [PC_W-1:0] STEP_MUL_G  = 4'd10;
  localparam logic [PC_W-1:0] STEP_TGT    = 4'd11;
  localparam logic [PC_W-1:0] STEP_DIFF   = 4'd12;
  localparam logic [PC_W-1:0] STEP_MUL_A  = 4'd13;
  localparam logic [PC_W-1:0] STEP_NEWQ   = 4'd14;
  localparam logic [PC_W-1:0] STEP_FIN    = 4'd15;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_REQ,
    COND_VIS,
    COND_TERM,
    COND_MORE_A,
    COND_MORE_S,
    COND_OUT_FREE
  } cond_e;

  typedef enum logic [1:0] {
    SSEL_S,
    SSEL_NS,
    SSEL_CNT
  } ssel_e;

  typedef enum logic {
    ASEL_A,
    ASEL_CNT
  } asel_e;

  typedef enum logic {
    WSEL_INIT,
    WSEL_NEWQ
  } wsel_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_MULG,
    DP_TGT,
    DP_DIFF,
    DP_MULA,
    DP_NEWQ,
    DP_FIN
  } dp_e;

  typedef struct packed {
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            hold;
    logic            cnt_loop;
    logic            vis_rd;
    logic            vis_wr;
    logic            vis_val;
    logic            q_rd;
    logic            q_wr;
    ssel_e           ssel;
    asel_e           asel;
    wsel_e           wsel;
    logic            mx_en;
    dp_e             dp;
  } cw_t;

  typedef struct packed {
    logic req;
    logic vis;
    logic term;
    logic out_free;
  } st_t;

  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '0;
    case (pc)
      STEP_CLR: begin
        cw.cond = COND_MORE_S; cw.target = STEP_CLR; cw.cnt_loop = 1'b1;
        cw.vis_wr = 1'b1; cw.vis_val = 1'b0; cw.ssel = SSEL_CNT;
      end
      STEP_IDLE: begin
        cw.cond = COND_REQ; cw.target = STEP_RD_VS; cw.hold = 1'b1;
      end
      STEP_RD_VS: begin
        cw.vis_rd = 1'b1; cw.ssel = SSEL_S;
      end
      STEP_CHK_S: begin
        cw.cond = COND_VIS; cw.target = STEP_RD_VN;
      end
      STEP_INIT_S: begin
        cw.cond = COND_MORE_A; cw.target = STEP_INIT_S; cw.cnt_loop = 1'b1;
        cw.q_wr = 1'b1; cw.ssel = SSEL_S; cw.asel = ASEL_CNT; cw.wsel = WSEL_INIT;
        cw.vis_wr = 1'b1; cw.vis_val = 1'b1;
      end
      STEP_RD_VN: begin
        cw.cond = COND_TERM; cw.target = STEP_RD_Q;
        cw.vis_rd = 1'b1; cw.ssel = SSEL_NS;
      end
      STEP_CHK_N: begin
        cw.cond = COND_VIS; cw.target = STEP_SCAN;
      end
      STEP_INIT_N: begin
        cw.cond = COND_MORE_A; cw.target = STEP_INIT_N; cw.cnt_loop = 1'b1;
        cw.q_wr = 1'b1; cw.ssel = SSEL_NS; cw.asel = ASEL_CNT; cw.wsel = WSEL_INIT;
        cw.vis_wr = 1'b1; cw.vis_val = 1'b1;
      end
      STEP_SCAN: begin
        cw.cond = COND_MORE_A; cw.target = STEP_SCAN; cw.cnt_loop = 1'b1;
        cw.q_rd = 1'b1; cw.ssel = SSEL_NS; cw.asel = ASEL_CNT; cw.mx_en = 1'b1;
      end
      STEP_RD_Q: begin
        cw.q_rd = 1'b1; cw.ssel = SSEL_S; cw.asel = ASEL_A; cw.mx_en = 1'b1;
      end
      STEP_MUL_G: cw.dp = DP_MULG;
      STEP_TGT:   cw.dp = DP_TGT;
      STEP_DIFF:  cw.dp = DP_DIFF;
      STEP_MUL_A: cw.dp = DP_MULA;
      STEP_NEWQ:  cw.dp = DP_NEWQ;
      STEP_FIN: begin
        cw.cond = COND_OUT_FREE; cw.target = STEP_IDLE; cw.hold = 1'b1;
        cw.q_wr = 1'b1; cw.ssel = SSEL_S; cw.asel = ASEL_A; cw.wsel = WSEL_NEWQ;
        cw.dp = DP_FIN;
      end
      default: begin
        cw.target = STEP_IDLE; cw.cond = COND_NONE;
      end
    endcase
    return cw;
  endfunction

endpackage

### sv/tabular_q_learning_update_unit.sv
// a request checks and, if unseen, initialises its state and then the next state, scans
// every action of the next state (next state skipped when terminal), reads the old entry,
// runs the datapath steps and waits in the result step until the output is free; one
// request at a time, set by the single q table port that scans the next state's actions;
// after rst_ni rises the visited map is cleared by a sweep over every state, with no
// request taken meanwhile; configuration writes are taken at any time
module tabular_q_learning_update_unit #(
  parameter int unsigned NUM_STATES  = 256,
  parameter int unsigned NUM_ACTIONS = 4,
  parameter int unsigned Q_WIDTH     = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // transition requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // state_index, action_taken, reward, next_state, zero pad
  input  logic [tqlu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // terminal
  input  logic                                s_axis_tlast,
  // episode_start
  input  logic                                s_axis_tuser,
  // update results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // new_q, change, episode_max_change, step_count, zero pad
  output logic [tqlu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // limit_reached
  output logic                                m_axis_tuser,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tqlu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tqlu_pkg::Q_FIELD_W-1:0]      cfg_data_i
);
  import tqlu_pkg::*;

  localparam int unsigned STATE_W = $clog2(NUM_STATES);
  localparam int unsigned ACT_W   = $clog2(NUM_ACTIONS);
  localparam int unsigned CNT_W   = (STATE_W > ACT_W) ? STATE_W : ACT_W;
  // stored q width, capped at the field width
  localparam int unsigned QW      = (Q_WIDTH > Q_FIELD_W) ? Q_FIELD_W : Q_WIDTH;
  localparam int unsigned SW      = QW + 18;  // wide form before saturation
  localparam int unsigned PGW     = QW + 17;  // gamma * maxq
  localparam int unsigned PAW     = QW + 18;  // alpha * diff
  localparam int unsigned DW      = QW + 1;   // exact difference
  localparam int unsigned QA_W    = STATE_W + ACT_W;
  localparam int unsigned Q_DEPTH = NUM_STATES * (2 ** ACT_W);
  localparam int unsigned ST_IN_N  = 2 ** ST_FIELD_W;
  localparam int unsigned ACT_IN_N = 2 ** ACT_FIELD_W;

  localparam logic signed [QW-1:0]  QMAX_Q = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0]  QMIN_Q = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [SW-1:0]  SAT_HI = SW'(QMAX_Q);
  localparam logic signed [SW-1:0]  SAT_LO = SW'(QMIN_Q);
  // half an lsb of the q0.16 product, round to nearest with ties up
  localparam logic signed [PGW-1:0] RND_G  = PGW'(32768);
  localparam logic signed [PAW-1:0] RND_A  = PAW'(32768);

  function automatic logic signed [QW-1:0] sat_q(input logic signed [SW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > SAT_HI) begin
      r = QMAX_Q;
    end else if (v < SAT_LO) begin
      r = QMIN_Q;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // sequencer
  cw_t              cw;
  st_t              st;
  logic [CNT_W-1:0] cnt;

  tqlu_seq #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cw_o   (cw),
    .cnt_o  (cnt)
  );

  // input field wrap tables, built at elaboration
  logic [STATE_W-1:0] st_wrap  [ST_IN_N];
  logic [ACT_W-1:0]   act_wrap [ACT_IN_N];

  for (genvar gi = 0; gi < ST_IN_N; gi++) begin : g_st_wrap
    assign st_wrap[gi] = STATE_W'(gi % NUM_STATES);
  end
  for (genvar gj = 0; gj < ACT_IN_N; gj++) begin : g_act_wrap
    assign act_wrap[gj] = ACT_W'(gj % NUM_ACTIONS);
  end

  // input fields
  logic [ST_FIELD_W-1:0]  in_state;
  logic [ACT_FIELD_W-1:0] in_action;
  logic signed [Q_FIELD_W-1:0] in_reward;
  logic [ST_FIELD_W-1:0]  in_next;
  logic                   in_fire;

  assign in_state  = s_axis_tdata[7:0];
  assign in_action = s_axis_tdata[9:8];
  assign in_reward = $signed(s_axis_tdata[41:10]);
  assign in_next   = s_axis_tdata[49:42];

  // ready only in the step that waits for a request
  assign s_axis_tready = (cw.cond == COND_REQ);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  logic [COEF_W-1:0]      lr_q;
  logic [COEF_W-1:0]      gamma_q;
  logic signed [QW-1:0]   init_q;
  logic [CNT_FIELD_W-1:0] max_steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q        <= LR_RESET;
      gamma_q     <= DISCOUNT_RESET;
      init_q      <= '0;
      max_steps_q <= MAX_STEPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEARNING_RATE:     lr_q        <= cfg_data_i[COEF_W-1:0];
        CFG_DISCOUNT:          gamma_q     <= cfg_data_i[COEF_W-1:0];
        // kept already saturated to the table width
        CFG_INITIAL_Q:         init_q      <= sat_q(SW'($signed(cfg_data_i)));
        CFG_MAX_EPISODE_STEPS: max_steps_q <= cfg_data_i[CNT_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // request registers
  logic [STATE_W-1:0]   s_q;
  logic [ACT_W-1:0]     a_q;
  logic [STATE_W-1:0]   ns_q;
  logic signed [QW-1:0] reward_q;
  logic                 term_q;
  logic                 start_q;

  // address selection from the control word
  logic [STATE_W-1:0] st_sel;
  logic [ACT_W-1:0]   act_sel;
  logic [QA_W-1:0]    q_addr;

  always_comb begin
    case (cw.ssel)
      SSEL_S:   st_sel = s_q;
      SSEL_NS:  st_sel = ns_q;
      SSEL_CNT: st_sel = cnt[STATE_W-1:0];
      default:  st_sel = s_q;
    endcase
    act_sel = (cw.asel == ASEL_CNT) ? cnt[ACT_W-1:0] : a_q;
  end

  assign q_addr = {st_sel, act_sel};

  // visited map, cleared by the sweep after reset
  logic vis_mem [NUM_STATES];
  logic vis_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cw.vis_wr) begin
      vis_mem[st_sel] <= cw.vis_val;
    end
    if (cw.vis_rd) begin
      vis_rdata_q <= vis_mem[st_sel];
    end
  end

  // q table, one shared port
  logic [QW-1:0]        q_mem [Q_DEPTH];
  logic [QW-1:0]        q_rdata_q;
  logic signed [QW-1:0] q_rd_s;
  logic signed [QW-1:0] q_wdata;
  logic signed [QW-1:0] newq_q;

  assign q_rd_s  = $signed(q_rdata_q);
  assign q_wdata = (cw.wsel == WSEL_NEWQ) ? newq_q : init_q;

  always_ff @(posedge clk_i) begin
    if (cw.q_wr) begin
      q_mem[q_addr] <= q_wdata;
    end
    if (cw.q_rd) begin
      q_rdata_q <= q_mem[q_addr];
    end
  end

  // read data of the previous step is valid for the max compare
  logic rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cw.q_rd;
    end
  end

  // datapath
  logic signed [QW-1:0]  maxq_q;
  logic signed [QW-1:0]  oldq_q;
  logic signed [PGW-1:0] prod_g_q;
  logic signed [QW-1:0]  target_q;
  logic signed [DW-1:0]  diff_q;
  logic signed [PAW-1:0] prod_a_q;

  logic signed [PGW-1:0] rnd_g;
  logic signed [DW-1:0]  gq;
  logic signed [PAW-1:0] rnd_a;
  logic signed [QW+1:0]  aq;

  assign rnd_g = prod_g_q + RND_G;
  assign gq    = $signed(rnd_g[PGW-1:16]);
  assign rnd_a = prod_a_q + RND_A;
  assign aq    = $signed(rnd_a[PAW-1:16]);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_q      <= st_wrap[in_state];
      a_q      <= act_wrap[in_action];
      ns_q     <= st_wrap[in_next];
      reward_q <= sat_q(SW'(in_reward));
      term_q   <= s_axis_tlast;
      start_q  <= s_axis_tuser;
      // terminal transitions use zero, else the scan starts from the floor
      maxq_q   <= s_axis_tlast ? '0 : QMIN_Q;
    end else if (cw.mx_en && rd_vld_q && (q_rd_s > maxq_q)) begin
      maxq_q   <= q_rd_s;
    end
    case (cw.dp)
      DP_MULG: begin
        oldq_q   <= q_rd_s;
        prod_g_q <= $signed({1'b0, gamma_q}) * maxq_q;
      end
      DP_TGT:  target_q <= sat_q(SW'(reward_q) + SW'(gq));
      DP_DIFF: diff_q   <= DW'(target_q) - DW'(oldq_q);
      DP_MULA: prod_a_q <= $signed({1'b0, lr_q}) * diff_q;
      DP_NEWQ: newq_q   <= sat_q(SW'(oldq_q) + SW'(aq));
      default: ;
    endcase
  end

  // episode tracking and result register
  logic [CNT_FIELD_W-1:0] step_cnt_q;
  logic [CHG_W-1:0]       maxchg_q;
  logic                   out_valid_q;
  logic [Q_FIELD_W-1:0]   out_newq_q;
  logic [CHG_W-1:0]       out_chg_q;
  logic [CHG_W-1:0]       out_max_q;
  logic [CNT_FIELD_W-1:0] out_cnt_q;
  logic                   out_lim_q;

  logic                   out_free;
  logic                   fin_fire;
  logic signed [33:0]     dq;
  logic [33:0]            dq_abs;
  logic [CHG_W-1:0]       chg;
  logic [CNT_FIELD_W-1:0] base_cnt;
  logic [CNT_FIELD_W-1:0] nxt_cnt;
  logic [CHG_W-1:0]       base_max;
  logic [CHG_W-1:0]       nxt_max;
  logic                   lim;

  assign out_free = !out_valid_q || m_axis_tready;
  assign fin_fire = (cw.dp == DP_FIN) && out_free;

  always_comb begin
    dq     = 34'(newq_q) - 34'(oldq_q);
    dq_abs = dq[33] ? -dq : dq;
    chg    = (|dq_abs[33:31]) ? CHG_MAX : dq_abs[CHG_W-1:0];
    // episode start clears both trackers before this step counts
    base_cnt = start_q ? '0 : step_cnt_q;
    nxt_cnt  = (base_cnt == '1) ? base_cnt : base_cnt + CNT_FIELD_W'(1);
    base_max = start_q ? '0 : maxchg_q;
    nxt_max  = (chg > base_max) ? chg : base_max;
    lim      = (max_steps_q != '0) && (nxt_cnt >= max_steps_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_cnt_q  <= '0;
      maxchg_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_fire) begin
        step_cnt_q  <= nxt_cnt;
        maxchg_q    <= nxt_max;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_newq_q <= Q_FIELD_W'(newq_q);
      out_chg_q  <= chg;
      out_max_q  <= nxt_max;
      out_cnt_q  <= nxt_cnt;
      out_lim_q  <= lim;
    end
  end

  assign st.req      = in_fire;
  assign st.vis      = vis_rdata_q;
  assign st.term     = term_q;
  assign st.out_free = out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_q, out_max_q, out_chg_q, out_newq_q};
  assign m_axis_tuser  = out_lim_q;

endmodule

### sv/tqlu_seq.sv
module tqlu_seq #(
  parameter int unsigned NUM_STATES  = 256,
  parameter int unsigned NUM_ACTIONS = 4,
  localparam int unsigned STATE_W = $clog2(NUM_STATES),
  localparam int unsigned ACT_W   = $clog2(NUM_ACTIONS),
  localparam int unsigned CNT_W   = (STATE_W > ACT_W) ? STATE_W : ACT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tqlu_pkg::st_t    st_i,
  output tqlu_pkg::cw_t    cw_o,
  output logic [CNT_W-1:0] cnt_o
);
  import tqlu_pkg::*;

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             taken;

  assign cw_o  = ucode(pc_q);
  assign cnt_o = cnt_q;

  always_comb begin
    case (cw_o.cond)
      COND_REQ:      taken = st_i.req;
      COND_VIS:      taken = st_i.vis;
      COND_TERM:     taken = st_i.term;
      COND_MORE_A:   taken = (cnt_q[ACT_W-1:0] != ACT_W'(NUM_ACTIONS - 1));
      COND_MORE_S:   taken = (cnt_q[STATE_W-1:0] != STATE_W'(NUM_STATES - 1));
      COND_OUT_FREE: taken = st_i.out_free;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = cw_o.target;
    end else if (cw_o.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
    cnt_d = cnt_q;
    if (cw_o.cnt_loop) begin
      // loops leave the counter at zero for the next one
      cnt_d = taken ? cnt_q + CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= STEP_CLR;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/tqlu_chk.sv
`include "tabular_q_learning_update_unit_macros.svh"

module tqlu_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  // nothing offered or taken in the cycle after reset is seen low
  `TQLU_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid && !s_axis_tready, "active during reset")

  // one item at a time: ready drops right after a request is taken
  `TQLU_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready held after request")

  // a waiting result stays offered
  `TQLU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // every result counts at least its own step
  `TQLU_ASSERT(a_step_nonzero, m_axis_tvalid |-> m_axis_tdata[109:94] != 16'd0, "zero step count")

  // the episode maximum covers the change of this step
  `TQLU_ASSERT(a_max_covers, m_axis_tvalid |-> m_axis_tdata[62:32] <= m_axis_tdata[93:63], "max below change")

endmodule

bind tabular_q_learning_update_unit tqlu_chk u_tqlu_chk (.*);

### tb/sv/tabular_q_learning_update_unit_test.sv
`timescale 1ns / 100ps

module tabular_q_learning_update_unit_test;
  import tqlu_pkg::*;

  localparam int unsigned NUM_ST  = 256;
  localparam int unsigned NUM_ACT = 4;
  localparam longint QMAX = 64'sh7FFF_FFFF;
  localparam longint QMIN = -64'sh8000_0000;
  localparam longint CHANGE_CAP = 64'sh7FFF_FFFF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct {
    logic [ST_FIELD_W-1:0]  state;
    logic [ACT_FIELD_W-1:0] act;
    logic [Q_FIELD_W-1:0]   reward;
    logic [ST_FIELD_W-1:0]  nxt;
    logic                   term;
    logic                   start;
  } transition_t;

  typedef struct {
    logic [Q_FIELD_W-1:0]   new_q;
    logic [CHG_W-1:0]       change;
    logic [CHG_W-1:0]       ep_max;
    logic [CNT_FIELD_W-1:0] steps;
    logic                   limit;
  } update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [Q_FIELD_W-1:0] cfg_data_i = '0;

  tabular_q_learning_update_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the block: q table, visited map, episode counters, registers
  longint q_mem [NUM_ST*NUM_ACT];
  bit seen [NUM_ST];
  longint ep_max_change = 0;
  int unsigned ep_steps = 0;
  logic [COEF_W-1:0] alpha = LR_RESET;
  logic [COEF_W-1:0] gamma = DISCOUNT_RESET;
  longint init_q = 0;
  logic [CNT_FIELD_W-1:0] step_limit = MAX_STEPS_RESET;

  transition_t transitions_q [$];
  update_t expected_updates [$];
  transition_t offered;
  int unsigned send_gap = 0, send_burst = 0;
  int unsigned recv_gap = 0, recv_burst = 0, hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;

  function automatic longint clamp_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // divide by 2^16, nearest, ties upward
  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // a state seen for the first time gets initial_q on every action
  function automatic void first_touch(int unsigned s);
    int unsigned a;
    if (seen[s]) return;
    for (a = 0; a < NUM_ACT; a++) q_mem[s*NUM_ACT + a] = clamp_q(init_q);
    seen[s] = 1'b1;
  endfunction

  function automatic update_t predict_update(transition_t t);
    update_t r;
    longint best, old_q, tgt, diff, nq, delta;
    int unsigned a, s, ns;
    s = t.state;
    ns = t.nxt;
    if (t.start) begin
      ep_steps = 0;
      ep_max_change = 0;
    end
    first_touch(s);
    best = 0;
    if (!t.term) begin
      first_touch(ns);
      best = q_mem[ns*NUM_ACT];
      for (a = 1; a < NUM_ACT; a++)
        if (q_mem[ns*NUM_ACT + a] > best) best = q_mem[ns*NUM_ACT + a];
    end
    old_q = q_mem[s*NUM_ACT + t.act];
    tgt = clamp_q(longint'($signed(t.reward)) + round_q16(longint'(gamma) * best));
    diff = tgt - old_q;
    nq = clamp_q(old_q + round_q16(longint'(alpha) * diff));
    q_mem[s*NUM_ACT + t.act] = nq;
    delta = nq - old_q;
    if (delta < 0) delta = -delta;
    if (delta > CHANGE_CAP) delta = CHANGE_CAP;
    if (delta > ep_max_change) ep_max_change = delta;
    if (ep_steps < 16'hFFFF) ep_steps++;
    r.new_q = nq[Q_FIELD_W-1:0];
    r.change = delta[CHG_W-1:0];
    r.ep_max = ep_max_change[CHG_W-1:0];
    r.steps = ep_steps[CNT_FIELD_W-1:0];
    r.limit = (step_limit != 0) && (ep_steps >= step_limit);
    return r;
  endfunction

  // mostly zero, some short gaps, rare long ones, now and then a gap-free burst
  function automatic int unsigned draw_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      burst = $urandom_range(40, 160);
      return 0;
    end
    if (r < 100) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: result %0d %s: expected %h, got %h", $time, results_seen, field,
             want, got);
    mismatch_count++;
  endtask

  // request driver: one transition offered at a time, popped from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      s_axis_tuser <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_updates.insert(expected_updates.size(), predict_update(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (transitions_q.size() != 0) begin
          offered = transitions_q.pop_front();
          s_axis_tvalid <= 1'b1;
          // state_index, action_taken, reward, next_state from bit 0 up
          s_axis_tdata <= IN_TDATA_W'({offered.nxt, offered.reward, offered.act,
                                       offered.state});
          s_axis_tlast <= offered.term;
          s_axis_tuser <= offered.start;
          send_gap = draw_gap(send_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    update_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_updates.size() == 0) begin
          flag_mismatch("unexpected result", '0, 64'(m_axis_tdata));
        end else begin
          want = expected_updates.pop_front();
          if (m_axis_tdata[Q_FIELD_W-1:0] !== want.new_q)
            flag_mismatch("new_q", 64'(want.new_q), 64'(m_axis_tdata[Q_FIELD_W-1:0]));
          if (m_axis_tdata[Q_FIELD_W +: CHG_W] !== want.change)
            flag_mismatch("change", 64'(want.change), 64'(m_axis_tdata[Q_FIELD_W +: CHG_W]));
          if (m_axis_tdata[Q_FIELD_W+CHG_W +: CHG_W] !== want.ep_max)
            flag_mismatch("episode_max_change", 64'(want.ep_max),
                          64'(m_axis_tdata[Q_FIELD_W+CHG_W +: CHG_W]));
          if (m_axis_tdata[Q_FIELD_W+2*CHG_W +: CNT_FIELD_W] !== want.steps)
            flag_mismatch("step_count", 64'(want.steps),
                          64'(m_axis_tdata[Q_FIELD_W+2*CHG_W +: CNT_FIELD_W]));
          if (m_axis_tuser !== want.limit)
            flag_mismatch("limit_reached", 64'(want.limit), 64'(m_axis_tuser));
        end
        // long stall twice in the run so the block backs up into its input
        if (results_seen == 60 || results_seen == 450) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = draw_gap(recv_burst);
      end
    end
  end

  // ends the run when nothing moves on any channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tabular_q_learning_update_unit_test: FAIL");
    $finish;
  end

  task automatic add_transition(int unsigned s, int unsigned a, logic [31:0] r,
                                int unsigned ns, bit term, bit start);
    transition_t t;
    t.state = s[ST_FIELD_W-1:0];
    t.act = a[ACT_FIELD_W-1:0];
    t.reward = r;
    t.nxt = ns[ST_FIELD_W-1:0];
    t.term = term;
    t.start = start;
    transitions_q.insert(transitions_q.size(), t);
  endtask

  // block idle: nothing queued, nothing offered, every result back
  task automatic drain();
    while (!(transitions_q.size() == 0 && !s_axis_tvalid && expected_updates.size() == 0))
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_FIELD_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE:     alpha = data[COEF_W-1:0];
      CFG_DISCOUNT:          gamma = data[COEF_W-1:0];
      CFG_INITIAL_Q:         init_q = longint'($signed(data));
      CFG_MAX_EPISODE_STEPS: step_limit = data[CNT_FIELD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_coeffs(logic [15:0] lr, logic [15:0] disc, logic [31:0] iq,
                            logic [15:0] lim);
    drain();
    write_reg(CFG_LEARNING_RATE, 32'(lr));
    write_reg(CFG_DISCOUNT, 32'(disc));
    write_reg(CFG_INITIAL_Q, iq);
    write_reg(CFG_MAX_EPISODE_STEPS, 32'(lim));
  endtask

  // states near a moving window so entries get revisited, sometimes anywhere
  function automatic int unsigned pick_state(int unsigned base);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NUM_ST - 1);
    return (base + $urandom_range(0, 15)) % NUM_ST;
  endfunction

  function automatic logic [31:0] pick_reward();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r < 5) return $urandom;
    return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
  endfunction

  // mostly well-formed episodes chained through next_state, some loose noise
  task automatic random_phase(int unsigned base, int unsigned count);
    int unsigned n, len, i, s, ns;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) == 0) begin
        add_transition($urandom_range(0, 255), $urandom_range(0, 3), $urandom,
                       $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        n++;
      end else begin
        len = $urandom_range(1, 20);
        s = pick_state(base);
        for (i = 0; i < len; i++) begin
          ns = pick_state(base);
          add_transition(s, $urandom_range(0, 3), pick_reward(), ns,
                         (i == len - 1) && ($urandom_range(0, 3) != 0), i == 0);
          s = ns;
        end
        n += len;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    for (int i = 0; i < NUM_ST*NUM_ACT; i++) q_mem[i] = 0;
    for (int i = 0; i < NUM_ST; i++) seen[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: fresh states, same state as next, terminal, ties
    add_transition(0, 0, 32'h0, 1, 1'b0, 1'b1);
    add_transition(1, 3, 32'h7FFF_FFFF, 1, 1'b0, 1'b0);
    add_transition(255, 2, 32'h8000_0000, 255, 1'b1, 1'b0);
    add_transition(0, 1, 32'h0001_0000, 0, 1'b0, 1'b0);
    add_transition(128, 1, 32'hFFFF_8000, 0, 1'b1, 1'b1);

    // full step and discount, largest initial value, limit of one step
    set_coeffs(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 16'd1);
    add_transition(10, 0, 32'h7FFF_FFFF, 11, 1'b0, 1'b1);
    add_transition(12, 1, 32'h8000_0000, 13, 1'b1, 1'b0);
    add_transition(12, 1, 32'h7FFF_FFFF, 10, 1'b0, 1'b0);
    add_transition(13, 2, 32'h8000_0000, 12, 1'b0, 1'b0);

    // zero step and discount, smallest initial value, longest limit
    set_coeffs(16'h0000, 16'h0000, 32'h8000_0000, 16'hFFFF);
    add_transition(20, 3, 32'h7FFF_FFFF, 21, 1'b0, 1'b1);
    add_transition(21, 0, 32'h8000_0000, 20, 1'b1, 1'b0);

    // half step: odd differences land exactly on rounding ties; limit after three
    set_coeffs(16'h8000, 16'h8000, 32'hFFFE_8000, 16'd3);
    add_transition(30, 0, 32'h0000_0001, 31, 1'b0, 1'b1);
    add_transition(31, 1, 32'hFFFF_FFFF, 32, 1'b0, 1'b0);
    add_transition(32, 2, 32'h0000_0003, 30, 1'b0, 1'b0);
    add_transition(30, 3, 32'hFFFF_FFFD, 31, 1'b0, 1'b0);
    add_transition(31, 0, 32'h0001_8001, 31, 1'b1, 1'b0);
    add_transition(40, 2, 32'h0000_0000, 41, 1'b0, 1'b1);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_coeffs(16'd6554, 16'd64881, 32'h0001_0000, 16'd0);
        1: set_coeffs(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 16'd10);
        2: set_coeffs(16'h0000, 16'h0000, 32'h8000_0000, 16'd1);
        3: set_coeffs(16'($urandom), 16'($urandom), $urandom, 16'($urandom_range(1, 30)));
        4: set_coeffs(16'd1, 16'hFFFF, $urandom, 16'hFFFF);
        default: set_coeffs(16'($urandom), 16'($urandom), $urandom,
                            $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 40)));
      endcase
      random_phase(48 + ph*36, 138);
    end

    drain();
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && expected_updates.size() == 0) begin
      $display("tabular_q_learning_update_unit_test: PASS");
    end else begin
      $display("tabular_q_learning_update_unit_test: FAIL");
    end
    $finish;
  end

endmodule

### tabular_q_learning_update_unit.f
+incdir+sv
sv/tqlu_pkg.sv
sv/tqlu_seq.sv
sv/tabular_q_learning_update_unit.sv
sv/tqlu_chk.sv
tb/sv/tabular_q_learning_update_unit_test.sv
